@@ hdl/pcf_pkg.sv @@
// Shared constants, types and the arctangent table for the pitch filter.
`timescale 1ns / 1ps
`default_nettype none

package pcf_pkg;

   // CORDIC iteration count, legal range 8 to 24
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int TAB_IDX_W    = 5;

   // Field widths
   localparam int ANGLE_W  = 16;
   localparam int RATE_W   = 16;
   localparam int DT_W     = 16;
   localparam int TIME_W   = 32;
   localparam int ALPHA_W  = 16;

   // Internal widths
   localparam int VEC_W    = 36;  // CORDIC x/y, inputs scaled by 2^16
   localparam int ZANG_W   = 28;  // CORDIC angle, 2^-24 rad units
   localparam int TILT_W   = 17;
   localparam int GYRO_W   = 36;  // pitch in 2^-31 rad units
   localparam int ACC_W    = 54;
   localparam int MUL_W    = 19;
   localparam int PROD_W   = 2 * MUL_W;

   localparam logic signed [ZANG_W-1:0] ANGLE_PI    = ZANG_W'(52707179);
   localparam logic signed [ZANG_W-1:0] TILT_ROUND  = ZANG_W'(1024);
   localparam logic [ALPHA_W-1:0]       BLEND_RESET = ALPHA_W'(64225);

   typedef struct packed {
      logic load;    // capture word, set up CORDIC
      logic iter;    // one CORDIC micro-rotation
      logic tilt;    // round tilt, integrate gyro
      logic diff;    // gyro minus tilt
      logic mul_lo;  // alpha times low half of diff
      logic mul_hi;  // alpha times high half of diff
      logic commit;  // update state and result register
   } pcf_cmd_type;

   typedef struct packed {
      logic reseed;
      logic sample_ok;
      logic seeded;
      logic iter_last;
   } pcf_status_type;

   // atan(2^-i) in 2^-24 rad units
   function automatic logic signed [ZANG_W-1:0] atan_angle(input logic [TAB_IDX_W-1:0] idx);
      logic signed [ZANG_W-1:0] a;
      unique case (idx)
         5'd0:  a = ZANG_W'(13176795);
         5'd1:  a = ZANG_W'(7778716);
         5'd2:  a = ZANG_W'(4110060);
         5'd3:  a = ZANG_W'(2086331);
         5'd4:  a = ZANG_W'(1047214);
         5'd5:  a = ZANG_W'(524117);
         5'd6:  a = ZANG_W'(262123);
         5'd7:  a = ZANG_W'(131069);
         5'd8:  a = ZANG_W'(65536);
         5'd9:  a = ZANG_W'(32768);
         5'd10: a = ZANG_W'(16384);
         5'd11: a = ZANG_W'(8192);
         5'd12: a = ZANG_W'(4096);
         5'd13: a = ZANG_W'(2048);
         5'd14: a = ZANG_W'(1024);
         5'd15: a = ZANG_W'(512);
         5'd16: a = ZANG_W'(256);
         5'd17: a = ZANG_W'(128);
         5'd18: a = ZANG_W'(64);
         5'd19: a = ZANG_W'(32);
         5'd20: a = ZANG_W'(16);
         5'd21: a = ZANG_W'(8);
         5'd22: a = ZANG_W'(4);
         5'd23: a = ZANG_W'(2);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

@@ hdl/pcf_ifaces.sv @@
// Handshake interfaces for the request, response and CSR write channels.
`timescale 1ns / 1ps
`default_nettype none

interface pcf_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic               sample_valid;
   logic signed [15:0] accel_forward;
   logic signed [15:0] accel_up;
   logic signed [15:0] gyro_rate;
   logic [15:0]        step_time;
   logic [31:0]        sample_time;
   logic signed [15:0] seed_pitch;

   modport source (output valid, req_type, sample_valid, accel_forward, accel_up,
                   gyro_rate, step_time, sample_time, seed_pitch, input ready);
   modport sink (input valid, req_type, sample_valid, accel_forward, accel_up,
                 gyro_rate, step_time, sample_time, seed_pitch, output ready);
endinterface

interface pcf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pitch;
   logic signed [15:0] pitch_rate;
   logic [31:0]        estimate_time;
   logic               estimate_valid;

   modport source (output valid, pitch, pitch_rate, estimate_time, estimate_valid,
                   input ready);
   modport sink (input valid, pitch, pitch_rate, estimate_time, estimate_valid,
                 output ready);
endinterface

interface pcf_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] blend_weight;

   modport source (output valid, blend_weight, input ready);
   modport sink (input valid, blend_weight, output ready);
endinterface

`default_nettype wire

@@ hdl/pitch_complementary_filter_unit.sv @@
// Pitch complementary filter: gyro integration blended with CORDIC accelerometer tilt.
`timescale 1ns / 1ps
`default_nettype none

// One request word at a time. A reseed or an invalid sample goes from the route
// state straight to commit. A valid sample runs the iterative CORDIC (one
// micro-rotation a cycle, CORDIC_STEPS of them) and the tilt step, then commits
// straight away before the first seeding; after it, the blend runs alpha times the
// error through one shared 19x19 multiplier in two halves before the commit.
// Request ready returns in the same cycle that the response word appears, even if
// that word has not been taken yet. blend_weight may be written at any time the
// unit is idle and resets to 64225.
module pitch_complementary_filter_unit (
   input wire logic clock,
   input wire logic reset,
   pcf_req_if.sink   req_bus,
   pcf_rsp_if.source rsp_bus,
   pcf_csr_if.sink   csr_bus
);
   import pcf_pkg::*;

   pcf_cmd_type    cmd;
   pcf_status_type status;

   assign csr_bus.ready = 1'b1;

   pcf_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   pcf_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_we             (csr_bus.valid),
      .csr_blend_weight   (csr_bus.blend_weight),
      .req_type           (req_bus.req_type),
      .req_sample_valid   (req_bus.sample_valid),
      .req_accel_forward  (req_bus.accel_forward),
      .req_accel_up       (req_bus.accel_up),
      .req_gyro_rate      (req_bus.gyro_rate),
      .req_step_time      (req_bus.step_time),
      .req_sample_time    (req_bus.sample_time),
      .req_seed_pitch     (req_bus.seed_pitch),
      .rsp_pitch          (rsp_bus.pitch),
      .rsp_pitch_rate     (rsp_bus.pitch_rate),
      .rsp_estimate_time  (rsp_bus.estimate_time),
      .rsp_estimate_valid (rsp_bus.estimate_valid)
   );

endmodule

`default_nettype wire

@@ hdl/pcf_datapath.sv @@
// Datapath: CORDIC tilt, gyro integration, blend, filter state and result register.
`timescale 1ns / 1ps
`default_nettype none

module pcf_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire pcf_pkg::pcf_cmd_type            cmd,
   output pcf_pkg::pcf_status_type              status,
   input  wire logic                            csr_we,
   input  wire logic [pcf_pkg::ALPHA_W-1:0]     csr_blend_weight,
   input  wire logic                            req_type,
   input  wire logic                            req_sample_valid,
   input  wire logic signed [pcf_pkg::ANGLE_W-1:0] req_accel_forward,
   input  wire logic signed [pcf_pkg::ANGLE_W-1:0] req_accel_up,
   input  wire logic signed [pcf_pkg::RATE_W-1:0]  req_gyro_rate,
   input  wire logic [pcf_pkg::DT_W-1:0]        req_step_time,
   input  wire logic [pcf_pkg::TIME_W-1:0]      req_sample_time,
   input  wire logic signed [pcf_pkg::ANGLE_W-1:0] req_seed_pitch,
   output logic signed [pcf_pkg::ANGLE_W-1:0]   rsp_pitch,
   output logic signed [pcf_pkg::RATE_W-1:0]    rsp_pitch_rate,
   output logic [pcf_pkg::TIME_W-1:0]           rsp_estimate_time,
   output logic                                 rsp_estimate_valid
);
   import pcf_pkg::*;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

   // configuration
   logic [ALPHA_W-1:0] alpha_ff;

   // filter state
   logic signed [ANGLE_W-1:0] pitch_ff, pitch_in;
   logic signed [RATE_W-1:0]  rate_ff, rate_in;
   logic [TIME_W-1:0]         time_ff, time_in;
   logic                      valid_ff, valid_in;
   logic                      seeded_ff, seeded_in;

   // captured word
   logic                      kind_reseed_ff;
   logic                      kind_ok_ff;
   logic signed [RATE_W-1:0]  rate_word_ff;
   logic [DT_W-1:0]           dt_word_ff;
   logic [TIME_W-1:0]         time_word_ff;
   logic signed [ANGLE_W-1:0] seed_word_ff;

   // CORDIC
   logic signed [VEC_W-1:0]  x_ff, x_in;
   logic signed [VEC_W-1:0]  y_ff, y_in;
   logic signed [ZANG_W-1:0] z_ff, z_in;
   logic signed [ZANG_W-1:0] offset_ff, offset_in;
   logic                     zero_ff;
   logic [STEP_W-1:0]        step_ff;

   // blend
   logic signed [TILT_W-1:0] tilt_ff, tilt_in;
   logic signed [GYRO_W-1:0] gyro_ff, gyro_in;
   logic signed [GYRO_W-1:0] diff_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [ZANG_W-1:0] zsum;
   logic signed [ACC_W-1:0]  acc_round;
   logic signed [ACC_W-35:0] blend_q;
   logic signed [ANGLE_W-1:0] blend_sat, tilt_sat;
   logic signed [16:0]       fwd_x, up_x;

   function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [ACC_W-35:0] v);
      logic signed [ACC_W-35:0] hi, lo;
      hi = (ACC_W-34)'(32767);
      lo = -(ACC_W-34)'(32768);
      if (v > hi) return 16'sh7FFF;
      else if (v < lo) return 16'sh8000;
      else return v[ANGLE_W-1:0];
   endfunction

   // CORDIC setup: vector (up, -forward), folded into the right half-plane
   always_comb begin
      fwd_x = 17'(req_accel_forward);
      up_x  = 17'(req_accel_up);
      if (req_accel_up < 0) begin
         x_in      = VEC_W'(-up_x) <<< 16;
         y_in      = VEC_W'(fwd_x) <<< 16;
         offset_in = (req_accel_forward < 0) ? ANGLE_PI : -ANGLE_PI;
      end else begin
         x_in      = VEC_W'(up_x) <<< 16;
         y_in      = VEC_W'(-fwd_x) <<< 16;
         offset_in = '0;
      end
      z_in = '0;
      if (cmd.iter) begin
         if (y_ff >= 0) begin
            x_in = x_ff + (y_ff >>> step_ff);
            y_in = y_ff - (x_ff >>> step_ff);
            z_in = z_ff + atan_angle(TAB_IDX_W'(step_ff));
         end else begin
            x_in = x_ff - (y_ff >>> step_ff);
            y_in = y_ff + (x_ff >>> step_ff);
            z_in = z_ff - atan_angle(TAB_IDX_W'(step_ff));
         end
         offset_in = offset_ff;
      end
   end

   // one shared multiplier for rate*dt and the two halves of alpha*diff
   always_comb begin
      if (cmd.tilt) begin
         mul_a = MUL_W'(rate_word_ff);
         mul_b = MUL_W'({1'b0, dt_word_ff});
      end else if (cmd.mul_lo) begin
         mul_a = MUL_W'({1'b0, alpha_ff});
         mul_b = MUL_W'({1'b0, diff_ff[17:0]});
      end else begin
         mul_a = MUL_W'({1'b0, alpha_ff});
         mul_b = MUL_W'($signed(diff_ff[GYRO_W-1:18]));
      end
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      zsum    = z_ff + offset_ff + TILT_ROUND;
      tilt_in = zero_ff ? '0 : TILT_W'(zsum >>> 11);
      gyro_in = (GYRO_W'(pitch_ff) <<< 18) + GYRO_W'(mul_p);
      if (cmd.mul_lo)
         acc_in = (ACC_W'(tilt_ff) <<< 34) + ACC_W'(mul_p);
      else
         acc_in = acc_ff + (ACC_W'(mul_p) <<< 18);
      acc_round = acc_ff + (ACC_W'(1) <<< 33);
      blend_q   = acc_round[ACC_W-1:34];
      blend_sat = sat_angle(blend_q);
      tilt_sat  = sat_angle((ACC_W-34)'(tilt_ff));
   end

   // next filter state
   always_comb begin
      pitch_in  = pitch_ff;
      rate_in   = rate_ff;
      time_in   = time_ff;
      valid_in  = valid_ff;
      seeded_in = seeded_ff;
      if (kind_reseed_ff) begin
         pitch_in  = seed_word_ff;
         rate_in   = '0;
         time_in   = '0;
         valid_in  = 1'b1;
         seeded_in = 1'b1;
      end else if (kind_ok_ff) begin
         pitch_in  = seeded_ff ? blend_sat : tilt_sat;
         rate_in   = rate_word_ff;
         time_in   = time_word_ff;
         valid_in  = 1'b1;
         seeded_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= BLEND_RESET;
         pitch_ff  <= '0;
         rate_ff   <= '0;
         time_ff   <= '0;
         valid_ff  <= 1'b0;
         seeded_ff <= 1'b0;
         step_ff   <= '0;
      end else begin
         if (csr_we)
            alpha_ff <= csr_blend_weight;
         if (cmd.commit) begin
            pitch_ff  <= pitch_in;
            rate_ff   <= rate_in;
            time_ff   <= time_in;
            valid_ff  <= valid_in;
            seeded_ff <= seeded_in;
         end
         if (cmd.load)
            step_ff <= '0;
         else if (cmd.iter)
            step_ff <= step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_reseed_ff <= req_type;
         kind_ok_ff     <= req_sample_valid;
         rate_word_ff   <= req_gyro_rate;
         dt_word_ff     <= req_step_time;
         time_word_ff   <= req_sample_time;
         seed_word_ff   <= req_seed_pitch;
         zero_ff        <= (req_accel_forward == 0) && (req_accel_up == 0);
      end
      if (cmd.load || cmd.iter) begin
         x_ff      <= x_in;
         y_ff      <= y_in;
         z_ff      <= z_in;
         offset_ff <= offset_in;
      end
      if (cmd.tilt) begin
         tilt_ff <= tilt_in;
         gyro_ff <= gyro_in;
      end
      if (cmd.diff)
         diff_ff <= gyro_ff - (GYRO_W'(tilt_ff) <<< 18);
      if (cmd.mul_lo || cmd.mul_hi)
         acc_ff <= acc_in;
      if (cmd.commit) begin
         rsp_pitch          <= pitch_in;
         rsp_pitch_rate     <= rate_in;
         rsp_estimate_time  <= time_in;
         rsp_estimate_valid <= valid_in;
      end
   end

   always_comb begin
      status.reseed    = kind_reseed_ff;
      status.sample_ok = kind_ok_ff;
      status.seeded    = seeded_ff;
      status.iter_last = (step_ff == STEP_LAST);
   end

   // an unseeded filter never reports a valid estimate
   a_valid_implies_seeded: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> seeded_ff)
      else $error("estimate valid without seeding");

   a_state_holds_without_commit: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.commit) && !$past(reset) |-> $stable(pitch_ff) && $stable(seeded_ff))
      else $error("filter state changed outside commit");

   a_step_reset_on_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> step_ff == '0)
      else $error("CORDIC step not cleared on load");

endmodule

`default_nettype wire

@@ hdl/pcf_controller.sv @@
// Controller: sequences one word through CORDIC, blend and commit.
`timescale 1ns / 1ps
`default_nettype none

module pcf_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output pcf_pkg::pcf_cmd_type         cmd,
   input  wire pcf_pkg::pcf_status_type status
);
   import pcf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROUTE,
      S_ITER,
      S_TILT,
      S_DIFF,
      S_MUL_LO,
      S_MUL_HI,
      S_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, out_free;

   assign accept   = req_valid && req_ready_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd        = '0;
      cmd.load   = accept;
      cmd.iter   = (state_ff == S_ITER);
      cmd.tilt   = (state_ff == S_TILT);
      cmd.diff   = (state_ff == S_DIFF);
      cmd.mul_lo = (state_ff == S_MUL_LO);
      cmd.mul_hi = (state_ff == S_MUL_HI);
      cmd.commit = (state_ff == S_COMMIT) && out_free;
   end

   always_comb begin
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in     = S_ROUTE;
               req_ready_in = 1'b0;
            end
         end
         S_ROUTE: begin
            if (status.reseed || !status.sample_ok)
               state_in = S_COMMIT;
            else
               state_in = S_ITER;
         end
         S_ITER: begin
            if (status.iter_last)
               state_in = S_TILT;
         end
         S_TILT: begin
            // first sample seeds straight from the tilt
            state_in = status.seeded ? S_DIFF : S_COMMIT;
         end
         S_DIFF:   state_in = S_MUL_LO;
         S_MUL_LO: state_in = S_MUL_HI;
         S_MUL_HI: state_in = S_COMMIT;
         S_COMMIT: begin
            if (out_free) begin
               state_in     = S_IDLE;
               req_ready_in = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready_ff |-> state_ff == S_IDLE)
      else $error("request ready outside idle");

   a_commit_presents_word: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff && req_ready_ff)
      else $error("commit did not present a response word");

   a_accept_starts_route: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_ROUTE && !req_ready_ff)
      else $error("accepted word not routed");

endmodule

`default_nettype wire
